### rtl/blg_pkg.sv
// Shared types, constants and discharge curve tables for the battery level gauge.
`default_nettype none

package blg_pkg;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int FS_W     = 12;
  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 5;
  localparam int POS_W    = 5;

  // Shared divider: dividend width, divisor and remainder width, and iteration counter width.
  localparam int DIV_W    = 24;
  localparam int DVS_W    = 12;
  localparam int ITER_W   = 5;

  // Interpolation arithmetic widths.
  localparam int SPAN_W   = 9;
  localparam int DP_W     = 4;
  localparam int NUM_W    = 13;
  localparam int SEG_W    = 4;

  localparam int SAMPLES_PER_READING_DEF = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THR = 2'd1;

  localparam logic [FS_W-1:0] FULL_SCALE_RESET = 12'd3300;
  localparam logic [MV_W-1:0] CHARGE_THR_RESET = 13'd4150;

  // ADC full-scale code; the conversion divides by this.
  localparam logic [DVS_W-1:0] ADC_FULL_CODE = 12'd4095;

  // Curve end points.
  localparam logic [MV_W-1:0]  MV_FULL  = 13'd4200;
  localparam logic [MV_W-1:0]  MV_EMPTY = 13'd3000;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;
  localparam int CURVE_LAST = 12;

  typedef enum logic [3:0] {
    S_ACC,
    S_CHECK,
    S_AVG_WAIT,
    S_MUL,
    S_MV,
    S_SEG,
    S_NUM,
    S_PCT_START,
    S_PCT_WAIT,
    S_PUBLISH
  } state_t;

  typedef enum logic [1:0] {
    DSEL_AVG,
    DSEL_PCT
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     clear;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_prod;
    logic     load_mv;
    logic     load_seg;
    logic     load_num;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic good_zero;
    logic div_done;
  } status_t;

  // LiPo discharge curve, highest voltage first.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    unique case (idx)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4150;
      4'd2:    v = 13'd4100;
      4'd3:    v = 13'd4000;
      4'd4:    v = 13'd3900;
      4'd5:    v = 13'd3800;
      4'd6:    v = 13'd3750;
      4'd7:    v = 13'd3700;
      4'd8:    v = 13'd3650;
      4'd9:    v = 13'd3600;
      4'd10:   v = 13'd3500;
      4'd11:   v = 13'd3300;
      4'd12:   v = 13'd3000;
      default: v = 13'd3000;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] p;
    unique case (idx)
      4'd0:    p = 7'd100;
      4'd1:    p = 7'd95;
      4'd2:    p = 7'd90;
      4'd3:    p = 7'd80;
      4'd4:    p = 7'd70;
      4'd5:    p = 7'd60;
      4'd6:    p = 7'd50;
      4'd7:    p = 7'd40;
      4'd8:    p = 7'd30;
      4'd9:    p = 7'd20;
      4'd10:   p = 7'd10;
      4'd11:   p = 7'd5;
      4'd12:   p = 7'd0;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/blg_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module blg_div
  import blg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [ITER_W-1:0] iter;
  logic              running;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= '0;
      end else if (running) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/blg_datapath.sv
// Accumulator, conversion arithmetic, curve lookup and result registers.
`default_nettype none

module blg_datapath
  import blg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output status_t                  status,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                sample_ok,
  input  wire logic [FS_W-1:0]     full_scale_mv,
  input  wire logic [MV_W-1:0]     charge_threshold_mv,
  output logic [MV_W-1:0]          battery_mv,
  output logic [PCT_W-1:0]         percent,
  output logic                     charging,
  output logic                     reading_valid
);

  logic [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]  good_count;
  logic [DIV_W-1:0]  prod;
  logic [MV_W-1:0]   mv;
  logic [PCT_W-1:0]  pct_base;
  logic [MV_W-1:0]   seg_lo;
  logic [SPAN_W-1:0] seg_span;
  logic [DP_W-1:0]   seg_dp;
  logic [NUM_W-1:0]  num;

  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic [FS_W-1:0]   prod_hi;
  logic [FS_W-1:0]   prod_lo;
  logic [FS_W:0]     fold;
  logic [FS_W-1:0]   adc_mv;

  logic [SEG_W-1:0]  seg_idx;
  logic [SEG_W-1:0]  seg_next;
  logic [PCT_W-1:0]  pct_base_next;
  logic [MV_W-1:0]   seg_lo_next;
  logic [SPAN_W-1:0] seg_span_next;
  logic [DP_W-1:0]   seg_dp_next;
  logic [SPAN_W-1:0] seg_off;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sample_sum <= '0;
      good_count <= '0;
    end else if (cmd.take && sample_ok) begin
      sample_sum <= SUM_W'(sample_sum + {{(SUM_W-SAMPLE_W){1'b0}}, sample});
      good_count <= good_count + 1'b1;
    end
  end

  assign status.good_zero = good_count == '0;
  assign status.div_done  = div_done;

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_AVG: begin
        div_dividend = {{(DIV_W-SUM_W){1'b0}}, sample_sum};
        div_divisor  = {{(DVS_W-CNT_W){1'b0}}, good_count};
      end
      DSEL_PCT: begin
        div_dividend = {{(DIV_W-NUM_W){1'b0}}, num};
        div_divisor  = {{(DVS_W-SPAN_W){1'b0}}, seg_span};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = ADC_FULL_CODE;
      end
    endcase
  end

  blg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Division by 4095: with prod = hi*4096 + lo, prod = hi*4095 + (hi + lo),
  // and hi + lo never exceeds 8190, so the quotient is hi plus zero, one or two.
  assign prod_hi = prod[DIV_W-1:FS_W];
  assign prod_lo = prod[FS_W-1:0];
  assign fold    = {1'b0, prod_hi} + {1'b0, prod_lo};
  assign adc_mv  = prod_hi + FS_W'(fold >= {1'b0, ADC_FULL_CODE})
                   + FS_W'(fold == {ADC_FULL_CODE, 1'b0});

  // Curve segment search: the lowest-numbered segment whose lower point is not above mv.
  always_comb begin
    seg_idx = '0;
    for (int i = CURVE_LAST - 1; i >= 0; i--) begin
      if (mv >= curve_mv(SEG_W'(i + 1))) begin
        seg_idx = SEG_W'(i);
      end
    end
    seg_next = seg_idx + 1'b1;
    if (mv >= MV_FULL || mv <= MV_EMPTY) begin
      // Saturated: a zero slope leaves the base value as the answer.
      pct_base_next = (mv >= MV_FULL) ? PCT_FULL : PCT_NONE;
      seg_lo_next   = '0;
      seg_span_next = SPAN_W'(1);
      seg_dp_next   = '0;
    end else begin
      pct_base_next = curve_pct(seg_next);
      seg_lo_next   = curve_mv(seg_next);
      seg_span_next = SPAN_W'(curve_mv(seg_idx) - curve_mv(seg_next));
      seg_dp_next   = DP_W'(curve_pct(seg_idx) - curve_pct(seg_next));
    end
  end

  assign seg_off = SPAN_W'(mv - seg_lo);

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod <= DIV_W'(div_q[FS_W-1:0]) * DIV_W'(full_scale_mv);
    end
    if (cmd.load_mv) begin
      mv <= {adc_mv, 1'b0};
    end
    if (cmd.load_seg) begin
      pct_base <= pct_base_next;
      seg_lo   <= seg_lo_next;
      seg_span <= seg_span_next;
      seg_dp   <= seg_dp_next;
    end
    if (cmd.load_num) begin
      num <= {{(NUM_W-SPAN_W){1'b0}}, seg_off} * {{(NUM_W-DP_W){1'b0}}, seg_dp};
    end
    if (cmd.res_load) begin
      if (status.good_zero) begin
        battery_mv    <= '0;
        percent       <= '0;
        charging      <= 1'b0;
        reading_valid <= 1'b0;
      end else begin
        battery_mv    <= mv;
        percent       <= PCT_W'(pct_base + div_q[PCT_W-1:0]);
        charging      <= mv > charge_threshold_mv;
        reading_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/blg_ctrl.sv
// Controller: sample counting, conversion sequencing and result beat handshake.
`default_nettype none

module blg_ctrl
  import blg_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  output logic         result_valid,
  input  wire logic    result_stall,
  output cmd_t         cmd,
  input  wire status_t status
);

  state_t            state;
  state_t            state_next;
  logic [POS_W-1:0]  batch_position;
  logic              slot_free;
  logic              last_take;

  assign slot_free = !result_valid || !result_stall;
  assign last_take = batch_position == POS_W'(SAMPLES_PER_READING - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_ACC;
      batch_position <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        batch_position <= last_take ? '0 : batch_position + 1'b1;
      end
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.div_sel  = DSEL_AVG;
    sample_stall = 1'b1;
    unique case (state)
      S_ACC: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.take = 1'b1;
          if (last_take) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.good_zero) begin
          state_next = S_PUBLISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_AVG;
          state_next    = S_AVG_WAIT;
        end
      end
      S_AVG_WAIT: begin
        if (status.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_prod = 1'b1;
        state_next    = S_MV;
      end
      S_MV: begin
        cmd.load_mv = 1'b1;
        state_next  = S_SEG;
      end
      S_SEG: begin
        cmd.load_seg = 1'b1;
        state_next   = S_NUM;
      end
      S_NUM: begin
        cmd.load_num = 1'b1;
        state_next   = S_PCT_START;
      end
      S_PCT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_PCT;
        state_next    = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        cmd.div_sel = DSEL_PCT;
        if (status.div_done) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/battery_level_gauge.sv
// Battery level gauge: top level with configuration registers, controller and datapath.
//
// The block averages a batch of 12-bit ADC samples and reports the battery
// voltage, a LiPo state of charge and a charging flag once per batch.
// Input channel (sample_valid / sample_stall): one beat carries one sample and
// its success flag. Failed samples count toward the batch but are not summed.
// Output channel (result_valid / result_stall): one beat per batch of
// SAMPLES_PER_READING input beats. When no sample of the batch succeeded the
// beat has reading_valid low and all other fields zero.
// Samples are taken one per cycle within a batch. After the last sample the
// input stalls while a shared restoring divider runs twice, for the average
// and the curve interpolation; the division by 4095 is a combinational fold.
// An all-failed batch skips both divisions. The result sits in an output
// register; the next batch is accepted while it waits. If the receiver still
// stalls a result when the next one is ready, the block holds the new result
// and keeps its input stalled until the slot frees. Configuration (cfg_we,
// cfg_index, cfg_data) must be written only while idle; the block itself does
// not enforce this. Unknown indexes are ignored. Reset restores the default full
// scale and threshold, empties the output register and starts a fresh batch.
`default_nettype none

module battery_level_gauge
  import blg_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  sample_ok,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [MV_W-1:0]            battery_mv,
  output logic [PCT_W-1:0]           percent,
  output logic                       charging,
  output logic                       reading_valid,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FS_W-1:0] full_scale_mv;
  logic [MV_W-1:0] charge_threshold_mv;
  cmd_t            cmd;
  status_t         status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv       <= FULL_SCALE_RESET;
      charge_threshold_mv <= CHARGE_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL_SCALE: full_scale_mv       <= cfg_data[FS_W-1:0];
        REG_CHARGE_THR: charge_threshold_mv <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  blg_ctrl #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  blg_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .sample              (sample),
    .sample_ok           (sample_ok),
    .full_scale_mv       (full_scale_mv),
    .charge_threshold_mv (charge_threshold_mv),
    .battery_mv          (battery_mv),
    .percent             (percent),
    .charging            (charging),
    .reading_valid       (reading_valid)
  );

endmodule

`default_nettype wire

### rtl/blg_checker.sv
// Port-level checks on the battery level gauge result channel, bound to the top level.
`default_nettype none

module blg_checker
  import blg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire logic [MV_W-1:0]  battery_mv,
  input wire logic [PCT_W-1:0] percent,
  input wire logic             charging,
  input wire logic             reading_valid
);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // The output register is empty right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // A failed batch reports all fields as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !reading_valid |-> battery_mv == '0 && percent == '0 && !charging)
    else $error("failed batch carries nonzero fields");

  // The state of charge follows the curve end points.
  a_pct_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> percent <= PCT_FULL
      && (battery_mv < MV_FULL || percent == PCT_FULL)
      && (battery_mv > MV_EMPTY || percent == PCT_NONE))
    else $error("percent inconsistent with battery voltage");

endmodule

bind battery_level_gauge blg_checker u_blg_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .battery_mv    (battery_mv),
  .percent       (percent),
  .charging      (charging),
  .reading_valid (reading_valid)
);

`default_nettype wire

### test/battery_level_gauge_tb.sv
// Testbench for the battery level gauge: random sample batches checked against a scoreboard.
module battery_level_gauge_tb;
  import blg_pkg::*;

  localparam int BATCH_LEN         = SAMPLES_PER_READING_DEF;
  localparam int BATCHES_PER_PHASE = 7;
  localparam int PHASES            = 8;
  localparam int SETTLE_CYCLES     = 120;
  localparam int LONG_HOLD_CYCLES  = 500;
  localparam int RUN_LIMIT         = 400000;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // LiPo discharge knees, highest voltage first.
  localparam int unsigned KNEE_MV [13] = '{4200, 4150, 4100, 4000, 3900, 3800, 3750,
                                           3700, 3650, 3600, 3500, 3300, 3000};
  localparam int unsigned KNEE_PCT [13] = '{100, 95, 90, 80, 70, 60, 50, 40, 30, 20,
                                            10, 5, 0};

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             chg;
    logic             ok;
  } reading_t;

  typedef enum {
    BATCH_CURVE,
    BATCH_SPREAD,
    BATCH_NOISE,
    BATCH_DEAD,
    BATCH_LONE,
    BATCH_EDGE
  } batch_kind_t;

  // Keeps its own copy of the registers and the batch accumulator, and
  // queues one expected reading per completed batch.
  class gauge_scoreboard;
    logic [FS_W-1:0]  full_scale;
    logic [MV_W-1:0]  charge_thr;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] good;
    logic [POS_W-1:0] pos;
    reading_t         readings_due[$];
    int               errors;

    function new();
      full_scale = FULL_SCALE_RESET;
      charge_thr = CHARGE_THR_RESET;
      sum        = '0;
      good       = '0;
      pos        = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FULL_SCALE) begin
        full_scale = data[FS_W-1:0];
      end else if (idx == REG_CHARGE_THR) begin
        charge_thr = data;
      end
    endfunction

    // Truncated linear interpolation between the two knees around mv.
    function logic [PCT_W-1:0] charge_percent(int unsigned mv);
      int unsigned pct;
      pct = 0;
      if (mv >= KNEE_MV[0]) begin
        pct = KNEE_PCT[0];
      end else if (mv > KNEE_MV[12]) begin
        for (int k = 1; k < 13; k++) begin
          if (mv >= KNEE_MV[k]) begin
            pct = KNEE_PCT[k] + ((mv - KNEE_MV[k]) * (KNEE_PCT[k-1] - KNEE_PCT[k]))
                  / (KNEE_MV[k-1] - KNEE_MV[k]);
            break;
          end
        end
      end
      return pct[PCT_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic ok);
      int unsigned avg;
      int unsigned mv;
      reading_t    r;
      if (ok) begin
        sum  = sum + SUM_W'(s);
        good = good + 1'b1;
      end
      pos = pos + 1'b1;
      if (pos < BATCH_LEN) return;
      // A batch with no good sample reports all zeros.
      r = '0;
      if (good != 0) begin
        avg   = 32'(sum) / 32'(good);
        mv    = 2 * ((avg * full_scale) / ADC_FULL_CODE);
        r.mv  = mv[MV_W-1:0];
        r.pct = charge_percent(mv);
        r.chg = (mv > charge_thr);
        r.ok  = 1'b1;
      end
      readings_due.push_back(r);
      sum  = '0;
      good = '0;
      pos  = '0;
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_reading(logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct, logic chg,
                                logic ok);
      reading_t want;
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("unexpected reading: mv=%0d pct=%0d chg=%0b valid=%0b",
                                  mv, pct, chg, ok));
        return;
      end
      want = readings_due.pop_front();
      if (mv !== want.mv || pct !== want.pct || chg !== want.chg || ok !== want.ok) begin
        report_mismatch($sformatf(
          {"reading mismatch: expected mv=%0d pct=%0d chg=%0b valid=%0b,",
           " got mv=%0d pct=%0d chg=%0b valid=%0b"},
          want.mv, want.pct, want.chg, want.ok, mv, pct, chg, ok));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  logic [SAMPLE_W-1:0]   sample;
  logic                  sample_ok;
  logic                  result_valid;
  logic                  result_stall;
  logic [MV_W-1:0]       battery_mv;
  logic [PCT_W-1:0]      percent;
  logic                  charging;
  logic                  reading_valid;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gauge_scoreboard sb;

  // Shared between the sender and the receiver: whether random gaps are
  // allowed right now, and a request for one long receiver hold-off.
  bit idle_on;
  int long_hold_req;

  battery_level_gauge u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .sample_ok    (sample_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .battery_mv   (battery_mv),
    .percent      (percent),
    .charging     (charging),
    .reading_valid(reading_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one sample beat, maybe after a short gap, and returns at the edge
  // where it was taken. Valid stays high so the next beat can follow at once.
  task automatic send_beat(logic [SAMPLE_W-1:0] s, logic ok);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    sample_ok    <= ok;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s, ok);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Called right after the last beat of a batch: the sender goes quiet until
  // every reading is back and the block has had time to settle.
  task automatic drain_readings();
    sample_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One whole batch. The curve kind sits around a level so that the average
  // lands on a chosen part of the discharge curve or near the charge threshold.
  task automatic send_batch(batch_kind_t kind);
    int   level;
    int   spread;
    int   lone;
    int   v;
    logic ok;
    level  = 0;
    spread = 0;
    lone   = $urandom_range(0, BATCH_LEN - 1);
    case (kind)
      BATCH_CURVE: begin
        if ($urandom_range(0, 3) == 0) begin
          v = int'(sb.charge_thr) + int'($urandom_range(0, 40)) - 20;
        end else begin
          v = $urandom_range(2900, 4300);
        end
        if (v < 0) v = 0;
        if (sb.full_scale == 0) begin
          level = $urandom_range(0, 4095);
        end else begin
          level = (v * 4095) / (2 * int'(sb.full_scale));
        end
        spread = $urandom_range(0, 6);
      end
      BATCH_SPREAD: begin
        level  = $urandom_range(0, 4095);
        spread = $urandom_range(0, 300);
      end
      BATCH_EDGE: begin
        case ($urandom_range(0, 2))
          0:       level = 4095;
          1:       level = 0;
          default: level = $urandom_range(1, 60);
        endcase
      end
      default: level = 0;
    endcase
    if (level > 4095) level = 4095;
    for (int k = 0; k < BATCH_LEN; k++) begin
      v = level + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      case (kind)
        BATCH_CURVE:  ok = ($urandom_range(0, 9) != 0);
        BATCH_SPREAD: ok = ($urandom_range(0, 4) != 0);
        BATCH_NOISE: begin
          v  = $urandom_range(0, 4095);
          ok = 1'($urandom_range(0, 1));
        end
        BATCH_DEAD: begin
          v  = $urandom_range(0, 4095);
          ok = 1'b0;
        end
        BATCH_LONE: begin
          ok = (k == lone);
          case ($urandom_range(0, 2))
            0:       v = 0;
            1:       v = 4095;
            default: v = $urandom_range(0, 4095);
          endcase
        end
        default: ok = 1'b1;
      endcase
      send_beat(v[SAMPLE_W-1:0], ok);
    end
  endtask

  function automatic batch_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return BATCH_CURVE;
    if (r < 60) return BATCH_SPREAD;
    if (r < 70) return BATCH_NOISE;
    if (r < 78) return BATCH_DEAD;
    if (r < 88) return BATCH_LONE;
    return BATCH_EDGE;
  endfunction

  // Receiver: checks every accepted result beat, then picks the stall for
  // the next cycle. A long hold-off request overrides the random bursts and
  // lets the block back up until it stalls its own input.
  initial begin
    int stall_left;
    stall_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && !result_stall) begin
        sb.check_reading(battery_mv, percent, charging, reading_valid);
      end
      if (long_hold_req > 0) begin
        stall_left    = long_hold_req;
        long_hold_req = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Stimulus: one batch whose samples all failed, then phases of random
  // batches under different register settings. Registers change only once
  // all readings of the previous phase are back.
  initial begin
    logic [SAMPLE_W-1:0] pattern;
    sb            = new();
    idle_on       = 1'b1;
    long_hold_req = 0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    sample_ok    <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_FULL_SCALE;
    cfg_data     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every sample fails, with the code field swinging between its extremes.
    for (int k = 0; k < BATCH_LEN; k++) begin
      case (k % 4)
        0:       pattern = '0;
        1:       pattern = '1;
        2:       pattern = 12'hAAA;
        default: pattern = 12'h555;
      endcase
      send_beat(pattern, 1'b0);
    end
    drain_readings();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          // Writes to unimplemented indexes must leave the defaults alone.
          write_reg(REG_SPARE_A, 13'($urandom_range(0, 8191)));
          write_reg(REG_SPARE_B, 13'($urandom_range(0, 8191)));
        end
        1: begin
          write_reg(REG_FULL_SCALE, 13'd4095);
          write_reg(REG_CHARGE_THR, 13'd0);
        end
        2: begin
          // Zero full scale: every good batch reads 0 mV but stays valid.
          write_reg(REG_FULL_SCALE, 13'd0);
          write_reg(REG_CHARGE_THR, 13'd8191);
        end
        3: begin
          write_reg(REG_FULL_SCALE, 13'd1000);
          write_reg(REG_CHARGE_THR, 13'd8000);
          long_hold_req = LONG_HOLD_CYCLES;
        end
        4: begin
          write_reg(REG_FULL_SCALE, 13'd4000);
          write_reg(REG_CHARGE_THR, 13'd4150);
        end
        5: begin
          write_reg(REG_FULL_SCALE, 13'($urandom_range(1000, 4000)));
          write_reg(REG_CHARGE_THR, 13'($urandom_range(0, 8000)));
          write_reg(REG_SPARE_A, 13'($urandom_range(0, 8191)));
        end
        6: begin
          write_reg(REG_FULL_SCALE, 13'd3300);
          write_reg(REG_CHARGE_THR, 13'd4150);
        end
        default: begin
          write_reg(REG_FULL_SCALE, 13'($urandom_range(0, 4095)));
          write_reg(REG_CHARGE_THR, 13'($urandom_range(0, 8191)));
        end
      endcase
      for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
        // The last phase runs at full rate on both sides.
        idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
        send_batch(pick_kind());
      end
      drain_readings();
    end

    if (sb.errors == 0 && sb.readings_due.size() == 0) begin
      $display("battery_level_gauge_tb: PASS");
    end else begin
      $display("battery_level_gauge_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("battery_level_gauge_tb: FAIL");
    $finish;
  end

endmodule

### battery_level_gauge.f
rtl/blg_pkg.sv
rtl/blg_div.sv
rtl/blg_datapath.sv
rtl/blg_ctrl.sv
rtl/battery_level_gauge.sv
rtl/blg_checker.sv
test/battery_level_gauge_tb.sv
